@@ hw/rtl/ipck_pkg.sv @@
// Shared types, constants and the ones'-complement adder for the checksum engine.
package ipck_pkg;

   // Frame bytes at or beyond this index are not summed
   localparam logic [15:0] MAX_FRAME_BYTES = 16'd2048;
   localparam logic [6:0]  LINK_HDR_RESET  = 7'd14;
   localparam logic [15:0] IP_HDR_BYTES    = 16'd20;
   localparam logic [15:0] TCP_HDR_END     = 16'd40;
   localparam logic [15:0] ADDR_WORD_START = 16'd12;
   localparam logic [15:0] TOT_LEN_HI_OFS  = 16'd2;
   localparam logic [15:0] TOT_LEN_LO_OFS  = 16'd3;
   localparam logic [15:0] MIN_TOTAL_LEN   = 16'd40;
   localparam logic [15:0] PROTO_TCP       = 16'd6;

   // Frame summary handed from the accumulator to the finishing stage
   typedef struct packed {
      logic [15:0] hdr_sum;
      logic [15:0] seg_sum;
      logic [15:0] total_len;
      logic [16:0] byte_count;
   } snap_type;

   // 16-bit add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

endpackage

@@ hw/rtl/ipck_frame.sv @@
// Per-byte frame tracking: position, header and segment sums, total length, frame snapshot.
module ipck_frame (
   input  logic                clock,
   input  logic                reset,
   input  logic [6:0]          link_hdr_len,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output logic                snap_valid,
   input  logic                snap_ready,
   output ipck_pkg::snap_type  snap
);
   import ipck_pkg::*;

   logic [15:0] pos_ff, pos_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [15:0] seg_ff, seg_in;
   logic [15:0] tlen_ff, tlen_in;
   logic        snap_valid_ff, snap_valid_in;
   snap_type    snap_ff, snap_in;

   logic        accept;
   logic        in_window;
   logic [15:0] ofs;
   logic        in_ip_hdr;
   logic [15:0] word;
   logic        add_seg;

   // Take a new word whenever the snapshot slot is free or draining
   assign in_ready = !snap_valid_ff || snap_ready;
   assign accept   = in_valid && in_ready;

   // Locate the byte inside the IP packet
   assign in_window = (pos_ff < MAX_FRAME_BYTES) && (pos_ff >= {9'b0, link_hdr_len});
   assign ofs       = pos_ff - {9'b0, link_hdr_len};
   assign in_ip_hdr = ofs < IP_HDR_BYTES;
   assign word      = ofs[0] ? {8'h00, in_byte} : {in_byte, 8'h00};
   assign add_seg   = in_window && (in_ip_hdr ? (ofs >= ADDR_WORD_START)
                                              : ((ofs < TCP_HDR_END) || (ofs < tlen_ff)));

   // Advance the running sums for this byte
   always_comb begin
      logic [15:0] hdr_n;
      logic [15:0] seg_n;
      logic [15:0] tlen_n;
      logic [15:0] pos_n;
      hdr_n  = (in_window && in_ip_hdr) ? oc_add(hdr_ff, word) : hdr_ff;
      seg_n  = add_seg ? oc_add(seg_ff, word) : seg_ff;
      tlen_n = tlen_ff;
      if (in_window && ofs == TOT_LEN_HI_OFS) begin
         tlen_n[15:8] = in_byte;
      end
      if (in_window && ofs == TOT_LEN_LO_OFS) begin
         tlen_n[7:0] = in_byte;
      end
      pos_n = (pos_ff == 16'hffff) ? pos_ff : pos_ff + 16'd1;

      snap_in.hdr_sum    = hdr_n;
      snap_in.seg_sum    = seg_n;
      snap_in.total_len  = tlen_n;
      snap_in.byte_count = {1'b0, pos_ff} + 17'd1;

      pos_in  = pos_ff;
      hdr_in  = hdr_ff;
      seg_in  = seg_ff;
      tlen_in = tlen_ff;
      if (accept) begin
         if (in_last) begin
            pos_in  = '0;
            hdr_in  = '0;
            seg_in  = '0;
            tlen_in = '0;
         end else begin
            pos_in  = pos_n;
            hdr_in  = hdr_n;
            seg_in  = seg_n;
            tlen_in = tlen_n;
         end
      end

      snap_valid_in = snap_valid_ff && !snap_ready;
      if (accept && in_last) begin
         snap_valid_in = 1'b1;
      end
   end

   // Hold frame state; clear it after the last word
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         hdr_ff        <= '0;
         seg_ff        <= '0;
         tlen_ff       <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         hdr_ff        <= hdr_in;
         seg_ff        <= seg_in;
         tlen_ff       <= tlen_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   // Capture the frame summary on the last word
   always_ff @(posedge clock) begin
      if (accept && in_last) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

@@ hw/rtl/ipck_final.sv @@
// Pseudo-header completion, length checks and the result register.
module ipck_final (
   input  logic                clock,
   input  logic                reset,
   input  logic [6:0]          link_hdr_len,
   input  logic                snap_valid,
   output logic                snap_ready,
   input  ipck_pkg::snap_type  snap,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [15:0]         out_ip_sum,
   output logic [15:0]         out_tcp_sum,
   output logic                out_len_err,
   output logic                out_short
);
   import ipck_pkg::*;

   logic        valid_ff, valid_in;
   logic [15:0] ip_sum_ff, tcp_sum_ff;
   logic        len_err_ff, short_ff;
   logic        load;
   logic [15:0] tcp_proto;
   logic [15:0] tcp_full;
   logic        len_err;
   logic [16:0] need;
   logic        short_fr;

   assign snap_ready = !valid_ff || out_ready;
   assign load       = snap_valid && snap_ready;

   // Fold in the protocol and length words of the pseudo-header
   assign tcp_proto = oc_add(snap.seg_sum, PROTO_TCP);
   assign tcp_full  = oc_add(tcp_proto, snap.total_len - IP_HDR_BYTES);

   // Check the frame length against the IP total length
   assign len_err  = snap.total_len < MIN_TOTAL_LEN;
   assign need     = {10'b0, link_hdr_len} + {1'b0, len_err ? MIN_TOTAL_LEN : snap.total_len};
   assign short_fr = (snap.byte_count < need) || (need > {1'b0, MAX_FRAME_BYTES});

   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the result word
   always_ff @(posedge clock) begin
      if (load) begin
         ip_sum_ff  <= snap.hdr_sum;
         tcp_sum_ff <= tcp_full;
         len_err_ff <= len_err;
         short_ff   <= short_fr;
      end
   end

   assign out_valid   = valid_ff;
   assign out_ip_sum  = ip_sum_ff;
   assign out_tcp_sum = tcp_sum_ff;
   assign out_len_err = len_err_ff;
   assign out_short   = short_ff;

endmodule

@@ hw/rtl/ip_tcp_checksum_engine_core.sv @@
// The last frame byte is captured in the frame summary register, then in the result register.
// Throughput: one byte per cycle unless a held frame summary waits on the result register; each sum adds once per byte.
// A frame summary register and the result register let new bytes flow while a result waits.
// Reset: link header length returns to 14, all frame sums and the byte position clear.
// Top level of the IPv4/TCP checksum engine.
module ip_tcp_checksum_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,   // link_header_len
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,     // [15:0] ip_header_sum, [31:16] tcp_sum
   output logic [1:0]  rsp_tuser      // [0] length_error, [1] short_frame
);
   import ipck_pkg::*;

   logic [6:0]  link_hdr_len_ff, link_hdr_len_in;
   logic        snap_valid;
   logic        snap_ready;
   snap_type    snap;
   logic [15:0] ip_sum;
   logic [15:0] tcp_sum;
   logic        len_err;
   logic        short_fr;

   // Configuration register
   assign link_hdr_len_in = csr_wr_en ? csr_wr_data : link_hdr_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_hdr_len_ff <= LINK_HDR_RESET;
      end else begin
         link_hdr_len_ff <= link_hdr_len_in;
      end
   end

   ipck_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .link_hdr_len (link_hdr_len_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_byte      (req_tdata),
      .in_last      (req_tlast),
      .snap_valid   (snap_valid),
      .snap_ready   (snap_ready),
      .snap         (snap)
   );

   ipck_final u_final (
      .clock        (clock),
      .reset        (reset),
      .link_hdr_len (link_hdr_len_ff),
      .snap_valid   (snap_valid),
      .snap_ready   (snap_ready),
      .snap         (snap),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_ip_sum   (ip_sum),
      .out_tcp_sum  (tcp_sum),
      .out_len_err  (len_err),
      .out_short    (short_fr)
   );

   assign rsp_tdata = {tcp_sum, ip_sum};
   assign rsp_tuser = {short_fr, len_err};

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for the IPv4/TCP checksum engine: byte frames in, sums checked per frame.
module tb_top;

   localparam int LINK_LEN_RESET = 14;
   localparam int IP_HDR_LEN     = 20;
   localparam int HDRS_LEN       = 40;
   localparam int ADDR_OFS       = 12;
   localparam int LEN_HI_OFS     = 2;
   localparam int LEN_LO_OFS     = 3;
   localparam int FRAME_LIMIT    = 2048;
   localparam int POS_MAX        = 65535;
   localparam logic [15:0] TCP_PROTO = 16'd6;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PRINT_CAP      = 40;

   typedef struct packed {
      logic [15:0] hdr_sum;
      logic [15:0] tcp_sum;
      logic        len_err;
      logic        short_fr;
   } frame_sums_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [6:0]  csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;      // [7:0] data_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [15:0] ip_header_sum, [31:16] tcp_sum
   logic [1:0]  rsp_tuser;          // [0] length_error, [1] short_frame

   // Local copy of the engine state
   int             link_len = LINK_LEN_RESET;
   int             frame_pos = 0;
   logic [15:0]    hdr_acc = '0;
   logic [15:0]    seg_acc = '0;
   logic [15:0]    tot_len = '0;
   frame_sums_type sums_due[$];

   int err_count = 0;
   int bytes_in = 0;
   int frames_in = 0;
   int sums_checked = 0;
   int quiet_cycles = 0;
   int hold_req = 0;
   bit idle_on = 1'b1;

   ip_tcp_checksum_engine_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // 16-bit add, carry out of bit 15 wrapped back into bit 0
   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      int s;
      s = int'(a) + int'(b);
      if (s > POS_MAX) s = s - POS_MAX;
      return s[15:0];
   endfunction

   // Even offsets from the IP header start are the high byte of a word
   function automatic logic [15:0] byte_word(input int ofs, input logic [7:0] b);
      return ofs[0] ? {8'h00, b} : {b, 8'h00};
   endfunction

   function automatic void clear_frame();
      frame_pos = 0;
      hdr_acc   = '0;
      seg_acc   = '0;
      tot_len   = '0;
   endfunction

   // Fold one accepted byte into the running sums; queue the sums on the last byte
   function automatic void accumulate_byte(input logic [7:0] b, input logic lst);
      int             p;
      int             q;
      int             need;
      frame_sums_type s;
      p = frame_pos;
      bytes_in++;
      if (p < FRAME_LIMIT && p >= link_len) begin
         q = p - link_len;
         if (q < IP_HDR_LEN) begin
            hdr_acc = fold_add(hdr_acc, byte_word(q, b));
            if (q == LEN_HI_OFS) tot_len[15:8] = b;
            else if (q == LEN_LO_OFS) tot_len[7:0] = b;
            if (q >= ADDR_OFS) seg_acc = fold_add(seg_acc, byte_word(q, b));
         end else if (q < HDRS_LEN || q < int'(tot_len)) begin
            seg_acc = fold_add(seg_acc, byte_word(q, b));
         end
      end
      if (frame_pos < POS_MAX) frame_pos++;
      if (lst) begin
         need       = link_len + ((tot_len < HDRS_LEN) ? HDRS_LEN : int'(tot_len));
         s.hdr_sum  = hdr_acc;
         s.tcp_sum  = fold_add(fold_add(seg_acc, TCP_PROTO), 16'(tot_len - IP_HDR_LEN));
         s.len_err  = (tot_len < HDRS_LEN);
         s.short_fr = (p + 1 < need) || (need > FRAME_LIMIT);
         sums_due.push_back(s);
         frames_in++;
         clear_frame();
      end
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      if (err_count < PRINT_CAP)
         $display("tb_top: mismatch on %s at result %0d: got 0x%0h, want 0x%0h",
                  what, sums_checked, got, want);
      err_count++;
   endtask

   // Compare one result word with the oldest pending frame
   task automatic compare_sums();
      frame_sums_type w;
      if (sums_due.size() == 0) begin
         flag_mismatch("result with no frame pending", int'(rsp_tdata), 0);
      end else begin
         w = sums_due.pop_front();
         sums_checked++;
         if (rsp_tdata[15:0] !== w.hdr_sum)
            flag_mismatch("ip_header_sum", int'(rsp_tdata[15:0]), int'(w.hdr_sum));
         if (rsp_tdata[31:16] !== w.tcp_sum)
            flag_mismatch("tcp_sum", int'(rsp_tdata[31:16]), int'(w.tcp_sum));
         if (rsp_tuser[0] !== w.len_err)
            flag_mismatch("length_error", int'(rsp_tuser[0]), int'(w.len_err));
         if (rsp_tuser[1] !== w.short_fr)
            flag_mismatch("short_frame", int'(rsp_tuser[1]), int'(w.short_fr));
      end
   endtask

   // Track register writes, accepted bytes and result words
   always @(posedge clock) begin
      if (reset) begin
         link_len = LINK_LEN_RESET;
         clear_frame();
      end else begin
         if (csr_wr_en) link_len = int'(csr_wr_data);
         if (req_tvalid && req_tready) accumulate_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) compare_sums();
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("tb_top: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_top: errors");
      $finish;
   end

   // Result side: random stalls, or a long hold-off on request
   initial begin : rsp_side
      int stall;
      forever begin
         if (hold_req > 0) begin
            stall = hold_req;
            hold_req = 0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 3);
         end else begin
            stall = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Offer one byte, maybe after a short gap; return at the edge that takes it
   task automatic send_byte(input logic [7:0] b, input logic lst);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Send len bytes; total length goes into IP header bytes 2 and 3, fill < 0 means random
   task automatic send_frame(input logic [15:0] tot, input int len, input int fill);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         if (i == link_len + LEN_HI_OFS) b = tot[15:8];
         else if (i == link_len + LEN_LO_OFS) b = tot[7:0];
         else if (fill < 0) b = 8'($urandom_range(0, 255));
         else b = fill[7:0];
         send_byte(b, i == len - 1);
      end
   endtask

   // Drop valid and wait until every pending result has come out
   task automatic drain_sums();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sums_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_link_len(input logic [6:0] v);
      drain_sums();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed frames, some cut short, some with a bad length, some noise
   task automatic random_frame();
      int kind;
      int tot;
      int full;
      kind = $urandom_range(0, 9);
      tot  = $urandom_range(HDRS_LEN, 90);
      if (kind == 7) tot = $urandom_range(0, HDRS_LEN - 1);
      else if (kind == 8) tot = $urandom_range(0, POS_MAX);
      full = link_len + ((tot < HDRS_LEN) ? HDRS_LEN : tot);
      case (kind)
         6: send_frame(16'(tot), $urandom_range(1, full - 1), -1);
         8: send_frame(16'(tot), $urandom_range(1, link_len + 60), -1);
         9: send_frame(16'(tot), full, -1);
         default: send_frame(16'(tot), full + $urandom_range(0, 4), -1);
      endcase
   endtask

   function automatic logic [6:0] pick_link_len();
      case ($urandom_range(0, 9))
         0: return 7'd0;
         1: return 7'd64;
         2: return 7'd127;
         3: return 7'($urandom_range(0, 127));
         default: return 7'($urandom_range(0, 20));
      endcase
   endfunction

   // Reset value of the link header length, exact and padded frames
   task automatic test_default_link();
      send_frame(16'd40, LINK_LEN_RESET + 40, -1);
      send_frame(16'd41, LINK_LEN_RESET + 41 + 3, -1);
      send_frame(16'd60, LINK_LEN_RESET + 60, -1);
      drain_sums();
   endtask

   // All-zero and all-one bytes
   task automatic test_field_extremes();
      send_frame(16'd0, LINK_LEN_RESET + 40, 8'h00);
      send_frame(16'hFFFF, 80, 8'hFF);
      send_frame(16'd40, LINK_LEN_RESET + 40, 8'hFF);
      drain_sums();
   endtask

   // Total length under 40: header still summed, payload skipped, pseudo length wraps
   task automatic test_short_total();
      send_frame(16'd0, LINK_LEN_RESET + 40, -1);
      send_frame(16'd39, LINK_LEN_RESET + 40, -1);
      send_frame(16'd20, LINK_LEN_RESET + 50, -1);
      drain_sums();
   endtask

   // Frames that end inside the link header, the IP header or the segment
   task automatic test_early_end();
      send_frame(16'd40, 1, -1);
      send_frame(16'd40, 10, -1);
      send_frame(16'h1234, LINK_LEN_RESET + LEN_LO_OFS, -1);
      send_frame(16'd40, LINK_LEN_RESET + 30, -1);
      send_frame(16'd60, LINK_LEN_RESET + 59, -1);
      drain_sums();
   endtask

   // Several link header lengths, the extremes among them
   task automatic test_link_settings();
      logic [6:0] lens[4] = '{7'd0, 7'd64, 7'd127, 7'd1};
      foreach (lens[i]) begin
         write_link_len(lens[i]);
         repeat (2) random_frame();
      end
      drain_sums();
   endtask

   // Hold the result side off while one-byte frames keep coming, so the input stalls
   task automatic test_output_hold();
      idle_on  = 1'b0;
      hold_req = HOLD_CYCLES;
      repeat (30) send_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat (4) random_frame();
      drain_sums();
      idle_on = 1'b1;
   endtask

   task automatic test_random_frames(input int byte_goal, input int frame_goal);
      int start_bytes;
      int start_frames;
      int n;
      start_bytes  = bytes_in;
      start_frames = frames_in;
      n = 0;
      while (bytes_in - start_bytes < byte_goal || frames_in - start_frames < frame_goal) begin
         if (n % 12 == 0) write_link_len(pick_link_len());
         random_frame();
         n++;
      end
      drain_sums();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_link();
      test_field_extremes();
      test_short_total();
      test_early_end();
      test_link_settings();
      test_output_hold();
      test_random_frames(250, 4);
      // closing stretch runs with no gaps on either side
      idle_on = 1'b0;
      test_random_frames(150, 3);
      repeat (8) @(posedge clock);
      if (sums_due.size() != 0)
         flag_mismatch("frames left without a result", sums_due.size(), 0);
      $display("tb_top: %0d bytes in %0d frames sent, %0d results checked, %0d mismatches",
               bytes_in, frames_in, sums_checked, err_count);
      $display("tb_top: link lengths 0 to 127, short and early-ending frames, %s",
               "bad total lengths and output hold-off");
      if (err_count == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule
